// ----- rtl/rc4_pkg.sv -----
// Package for the RC4 stream cipher engine: sizes, command codes, sequencer
// states and the structs passed between the engine's modules.
// Depends on nothing; every RTL file but rc4_ram imports it.
`default_nettype none

package rc4_pkg;

  localparam int TABLE_SIZE    = 256;
  localparam int MAX_KEY_BYTES = 256;
  localparam int BYTE_W        = 8;
  localparam int KLEN_W        = 9;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  localparam logic [KLEN_W-1:0] KEY_LENGTH_RESET = KLEN_W'(16);
  localparam logic [0:0]        REG_KEY_LENGTH   = 1'b0;

  typedef enum logic [1:0] {
    OP_KEY_WR = 2'd0,
    OP_SCHED  = 2'd1,
    OP_DATA   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_D_RDJ,
    ST_D_SWAP,
    ST_D_FIN,
    ST_S_RD,
    ST_S_ACC,
    ST_S_SWAP,
    ST_S_WB
  } state_e;

  // Operand choice for the shared byte adder.
  typedef enum logic [1:0] {
    ADD_I_INC,
    ADD_J_STEP,
    ADD_SEL,
    ADD_ACC
  } add_sel_e;

  typedef struct packed {
    logic [BYTE_W-1:0] idx_i;
    logic [BYTE_W-1:0] idx_j;
    logic [BYTE_W-1:0] si;
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] perm_rd;
    logic [BYTE_W-1:0] key_rd;
  } add_src_t;

  typedef struct packed {
    logic              clear;
    logic              we;
    logic [BYTE_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] raddr;
  } perm_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/rc4_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined after reset.
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/rc4_perm_store.sv -----
// Permutation table: a RAM plus one valid flag per entry, so that an entry
// not written since the last clear reads back as its own index (identity).
// Depends on rc4_pkg and rc4_ram.
`default_nettype none

module rc4_perm_store
  import rc4_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire perm_ctrl_t        ctrl_i,
  output logic      [BYTE_W-1:0] rdata_o
);

  logic [TABLE_SIZE-1:0] valid_q;
  logic [TABLE_SIZE-1:0] valid_d;
  logic                  valid_rd_q;
  logic [BYTE_W-1:0]     raddr_q;
  logic [BYTE_W-1:0]     ram_rdata;

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.we),
    .waddr_i (ctrl_i.waddr),
    .wdata_i (ctrl_i.wdata),
    .raddr_i (ctrl_i.raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = '0;
    end else if (ctrl_i.we) begin
      valid_d[ctrl_i.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      valid_rd_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      valid_rd_q <= valid_q[ctrl_i.raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= ctrl_i.raddr;
  end

  assign rdata_o = valid_rd_q ? ram_rdata : raddr_q;

endmodule

`default_nettype wire

// ----- rtl/rc4_adder.sv -----
// Shared modulo-256 byte adder of the RC4 sequencer, with its operand select.
// Depends on rc4_pkg.
`default_nettype none

module rc4_adder
  import rc4_pkg::*;
(
  input  wire add_sel_e          sel_i,
  input  wire add_src_t          src_i,
  output logic      [BYTE_W-1:0] sum_o
);

  logic [BYTE_W-1:0] op_a;
  logic [BYTE_W-1:0] op_b;
  logic [BYTE_W-1:0] op_c;

  always_comb begin
    op_c = '0;
    unique case (sel_i)
      ADD_I_INC: begin
        op_a = src_i.idx_i;
        op_b = BYTE_W'(1);
      end
      ADD_J_STEP: begin
        op_a = src_i.idx_j;
        op_b = src_i.perm_rd;
      end
      ADD_SEL: begin
        op_a = src_i.si;
        op_b = src_i.perm_rd;
      end
      ADD_ACC: begin
        op_a = src_i.acc;
        op_b = src_i.perm_rd;
        op_c = src_i.key_rd;
      end
      default: begin
        op_a = src_i.idx_i;
        op_b = '0;
      end
    endcase
  end

  assign sum_o = op_a + op_b + op_c;

endmodule

`default_nettype wire

// ----- rtl/rc4_stream_cipher_top.sv -----
// Top level of the RC4 stream cipher engine: stream ports, register port,
// sequencer, key store, and the output register.
// Depends on rc4_pkg, rc4_ram, rc4_perm_store and rc4_adder.
//
//   Channel  Direction  Beat contents
//   s_axis   in         tuser = op, tdata = key_index, value, tlast = last
//   m_axis   out        tdata = out_byte, tlast = out_last
//   APB      in/out     key_length at byte address 0
//
// A key write is taken in IDLE; a data byte passes D_RDJ, D_SWAP and D_FIN (two dependent
// reads, the swap write-back and the keystream read all share the one permutation RAM
// port pair), and a schedule runs S_RD, S_ACC, S_SWAP and S_WB once per swap step, 256 steps.
// After reset the permutation is the identity and both indices are zero;
// per-entry valid flags provide the identity, so no clearing pass is needed.
// A finished byte sits in the output register; a stalled m_axis holds the
// engine in its last data state only if a second byte completes meanwhile.
`default_nettype none

module rc4_stream_cipher_top
  import rc4_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Input stream
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [15:0]        s_axis_tdata,  // [7:0] key_index, [15:8] value
  input  wire logic [1:0]         s_axis_tuser,  // [1:0] op
  input  wire logic               s_axis_tlast,
  // Output stream
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [7:0]         m_axis_tdata,  // [7:0] out_byte
  output logic                    m_axis_tlast,
  // Register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  state_e state_q, state_d;

  logic [KLEN_W-1:0] key_length_q;
  logic [KLEN_W-1:0] eff_len;
  logic [KLEN_W-1:0] kpos_inc;

  logic [BYTE_W-1:0] i_q, i_d;
  logic [BYTE_W-1:0] j_q, j_d;
  logic [BYTE_W-1:0] si_q, si_d;
  logic [BYTE_W-1:0] sj_q, sj_d;
  logic [BYTE_W-1:0] sel_q, sel_d;
  logic [BYTE_W-1:0] acc_q, acc_d;
  logic [BYTE_W-1:0] s_q, s_d;
  logic [BYTE_W-1:0] kpos_q, kpos_d;
  logic              last_q;
  logic              last_d;
  logic [BYTE_W-1:0] data_q;
  logic [BYTE_W-1:0] data_d;

  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;
  logic              out_load;
  logic [BYTE_W-1:0] keystream;

  logic              in_accept;
  op_e               in_op;
  logic              key_we;
  logic [BYTE_W-1:0] key_rd;
  logic [BYTE_W-1:0] perm_rd;
  logic [BYTE_W-1:0] sum;
  perm_ctrl_t        perm_ctrl;
  add_sel_e          add_sel;
  add_src_t          add_src;
  logic              cfg_we;

  // ---------------- Register port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_KEY_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= KEY_LENGTH_RESET;
    end else if (cfg_we) begin
      key_length_q <= pwdata[KLEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_KEY_LENGTH) begin
      prdata = PDATA_W'(key_length_q);
    end
  end

  // A zero length acts as one, anything above the key store size as its size.
  always_comb begin
    if (key_length_q == '0) begin
      eff_len = KLEN_W'(1);
    end else if (key_length_q > KLEN_W'(MAX_KEY_BYTES)) begin
      eff_len = KLEN_W'(MAX_KEY_BYTES);
    end else begin
      eff_len = key_length_q;
    end
  end

  assign kpos_inc = {1'b0, kpos_q} + KLEN_W'(1);

  // ---------------- Input side ----------------
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_op         = op_e'(s_axis_tuser);
  assign key_we        = in_accept && (in_op == OP_KEY_WR);

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_KEY_BYTES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (s_axis_tdata[7:0]),
    .wdata_i (s_axis_tdata[15:8]),
    .raddr_i (kpos_q),
    .rdata_o (key_rd)
  );

  rc4_perm_store u_perm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (perm_ctrl),
    .rdata_o (perm_rd)
  );

  always_comb begin
    add_src.idx_i   = i_q;
    add_src.idx_j   = j_q;
    add_src.si      = si_q;
    add_src.acc     = acc_q;
    add_src.perm_rd = perm_rd;
    add_src.key_rd  = key_rd;
  end

  rc4_adder u_adder (
    .sel_i (add_sel),
    .src_i (add_src),
    .sum_o (sum)
  );

  // Keystream byte: the swapped pair is forwarded, since its write-back is
  // not yet visible to the read of the selected entry.
  always_comb begin
    if (sel_q == j_q) begin
      keystream = si_q;
    end else if (sel_q == i_q) begin
      keystream = sj_q;
    end else begin
      keystream = perm_rd;
    end
  end

  assign out_load = (state_q == ST_D_FIN) && (!out_valid_q || m_axis_tready);

  // ---------------- Sequencer: next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_op)
            OP_SCHED: state_d = ST_S_RD;
            OP_DATA:  state_d = ST_D_RDJ;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_D_RDJ:  state_d = ST_D_SWAP;
      ST_D_SWAP: state_d = ST_D_FIN;
      ST_D_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      ST_S_RD:   state_d = ST_S_ACC;
      ST_S_ACC:  state_d = ST_S_SWAP;
      ST_S_SWAP: state_d = ST_S_WB;
      ST_S_WB: begin
        state_d = (s_q == BYTE_W'(TABLE_SIZE - 1)) ? ST_IDLE : ST_S_RD;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // ---------------- Sequencer: outputs ----------------
  always_comb begin
    i_d    = i_q;
    j_d    = j_q;
    si_d   = si_q;
    sj_d   = sj_q;
    sel_d  = sel_q;
    acc_d  = acc_q;
    s_d    = s_q;
    kpos_d = kpos_q;
    last_d = last_q;
    data_d = data_q;

    add_sel         = ADD_I_INC;
    perm_ctrl.clear = 1'b0;
    perm_ctrl.we    = 1'b0;
    perm_ctrl.waddr = i_q;
    perm_ctrl.wdata = si_q;
    perm_ctrl.raddr = sum;

    unique case (state_q)
      ST_IDLE: begin
        // Entry i+1 is fetched speculatively every idle cycle.
        add_sel = ADD_I_INC;
        if (in_accept) begin
          case (in_op)
            OP_DATA: begin
              i_d    = sum;
              data_d = s_axis_tdata[15:8];
              last_d = s_axis_tlast;
            end
            OP_SCHED: begin
              perm_ctrl.clear = 1'b1;
              i_d    = '0;
              j_d    = '0;
              acc_d  = '0;
              s_d    = '0;
              kpos_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_D_RDJ: begin
        add_sel = ADD_J_STEP;
        si_d    = perm_rd;
        j_d     = sum;
      end
      ST_D_SWAP: begin
        add_sel         = ADD_SEL;
        perm_ctrl.we    = 1'b1;
        perm_ctrl.waddr = i_q;
        perm_ctrl.wdata = perm_rd;
        sj_d            = perm_rd;
        sel_d           = sum;
      end
      ST_D_FIN: begin
        perm_ctrl.we    = 1'b1;
        perm_ctrl.waddr = j_q;
        perm_ctrl.wdata = si_q;
        perm_ctrl.raddr = sel_q;
      end
      ST_S_RD: begin
        perm_ctrl.raddr = s_q;
      end
      ST_S_ACC: begin
        add_sel = ADD_ACC;
        si_d    = perm_rd;
        acc_d   = sum;
      end
      ST_S_SWAP: begin
        perm_ctrl.we    = 1'b1;
        perm_ctrl.waddr = s_q;
        perm_ctrl.wdata = perm_rd;
        perm_ctrl.raddr = acc_q;
      end
      ST_S_WB: begin
        perm_ctrl.we    = 1'b1;
        perm_ctrl.waddr = acc_q;
        perm_ctrl.wdata = si_q;
        perm_ctrl.raddr = s_q;
        s_d             = s_q + BYTE_W'(1);
        kpos_d          = (kpos_inc >= eff_len) ? '0 : kpos_inc[BYTE_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_load || (out_valid_q && !m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    si_q   <= si_d;
    sj_q   <= sj_d;
    sel_q  <= sel_d;
    acc_q  <= acc_d;
    s_q    <= s_d;
    kpos_q <= kpos_d;
    last_q <= last_d;
    data_q <= data_d;
    if (out_load) begin
      out_byte_q <= data_q ^ keystream;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for rc4_stream_cipher_top: key writes, key schedules and data
// beats go in on s_axis, and an in-bench RC4 predictor checks every m_axis beat.
// Depends on rc4_pkg and the engine RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rc4_pkg::*;

  localparam logic [1:0]         OP_IGNORED      = 2'd3;
  localparam logic [PADDR_W-1:0] KEY_LENGTH_ADDR = PADDR_W'(4 * REG_KEY_LENGTH);
  // A schedule gives no output beat; SCHED_SETTLE covers its whole run plus a margin.
  localparam int                 SCHED_SETTLE    = 1 + 4 * TABLE_SIZE + 64;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
  } cipher_beat_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic [15:0]         s_axis_tdata  = '0;
  logic [1:0]          s_axis_tuser  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tready = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [PADDR_W-1:0]  paddr         = '0;
  logic [PDATA_W-1:0]  pwdata        = '0;
  wire                 s_axis_tready;
  wire                 m_axis_tvalid;
  wire  [7:0]          m_axis_tdata;
  wire                 m_axis_tlast;
  wire  [PDATA_W-1:0]  prdata;
  wire                 pready;

  // Predictor state of the cipher.
  logic [BYTE_W-1:0]   perm_mem [TABLE_SIZE];
  logic [BYTE_W-1:0]   key_mem [MAX_KEY_BYTES];
  bit                  key_loaded [MAX_KEY_BYTES];
  logic [BYTE_W-1:0]   ks_i;
  logic [BYTE_W-1:0]   ks_j;
  logic [KLEN_W-1:0]   key_len_reg;

  cipher_beat_t        pending_cipher[$];
  int                  error_count = 0;
  int                  beats_sent  = 0;
  int                  stall_left  = 0;
  bit                  send_gaps   = 1'b1;
  bit                  recv_stalls = 1'b1;

  always #2 clk_i = ~clk_i;

  rc4_stream_cipher_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] key_index, [15:8] value
    .s_axis_tuser  (s_axis_tuser),   // [1:0] op
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Zero selects one key byte, anything past the store size selects all of them.
  function automatic int unsigned used_key_bytes();
    if (key_len_reg == '0) return 1;
    if (key_len_reg > MAX_KEY_BYTES) return MAX_KEY_BYTES;
    return key_len_reg;
  endfunction

  function automatic void swap_perm(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] t;
    t           = perm_mem[a];
    perm_mem[a] = perm_mem[b];
    perm_mem[b] = t;
  endfunction

  function automatic void rekey_perm();
    int unsigned       len;
    int unsigned       kpos;
    logic [BYTE_W-1:0] acc;
    len  = used_key_bytes();
    kpos = 0;
    acc  = '0;
    ks_i = '0;
    ks_j = '0;
    for (int s = 0; s < TABLE_SIZE; s++) perm_mem[s] = BYTE_W'(s);
    for (int s = 0; s < TABLE_SIZE; s++) begin
      acc = acc + perm_mem[s] + key_mem[kpos];
      swap_perm(BYTE_W'(s), acc);
      kpos++;
      if (kpos >= len) kpos = 0;
    end
  endfunction

  function automatic logic [BYTE_W-1:0] keystream_next();
    logic [BYTE_W-1:0] sel;
    ks_i = ks_i + 8'd1;
    ks_j = ks_j + perm_mem[ks_i];
    swap_perm(ks_i, ks_j);
    sel = perm_mem[ks_i] + perm_mem[ks_j];
    return perm_mem[sel];
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    error_count++;
  endtask

  // Presents one beat, waits for the handshake and updates the predictor.
  // Valid is left high so that a following beat can go out back to back.
  task automatic send_beat(input logic [1:0] op, input logic [7:0] kidx,
                           input logic [7:0] val, input logic lst);
    int           gap;
    cipher_beat_t beat;
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, kidx};
    s_axis_tuser  <= op;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    case (op)
      OP_KEY_WR: begin
        key_mem[kidx]    = val;
        key_loaded[kidx] = 1'b1;
      end
      OP_SCHED: rekey_perm();
      OP_DATA: begin
        beat.out_byte = val ^ keystream_next();
        beat.out_last = lst;
        pending_cipher.push_back(beat);
      end
      default: ;
    endcase
    if (op != OP_IGNORED) beats_sent++;
  endtask

  // Stops sending and waits until every predicted byte has come out.
  task automatic pause_stream();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_cipher.size() != 0);
  endtask

  task automatic set_key_length(input logic [KLEN_W-1:0] len);
    pause_stream();
    // A schedule may still be running even though no byte is outstanding.
    repeat (SCHED_SETTLE) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KEY_LENGTH_ADDR;
    pwdata  <= PDATA_W'(len);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    key_len_reg = len;
  endtask

  // Loads any key byte the schedule would read that was never written, then starts the schedule.
  task automatic run_key_schedule();
    for (int k = 0; k < used_key_bytes(); k++) begin
      if (!key_loaded[k]) send_beat(OP_KEY_WR, 8'(k), 8'($urandom), 1'($urandom));
    end
    send_beat(OP_SCHED, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic send_message(input int n_bytes, input bit broken);
    logic lst;
    for (int i = 0; i < n_bytes; i++) begin
      lst = broken ? 1'($urandom) : (i == n_bytes - 1);
      send_beat(OP_DATA, 8'($urandom), 8'($urandom), lst);
    end
  endtask

  // Data right after reset runs on the identity permutation; op 3 is dropped.
  task automatic test_identity_permutation();
    send_beat(OP_DATA, 8'h00, 8'h00, 1'b0);
    send_beat(OP_IGNORED, 8'hFF, 8'hFF, 1'b1);
    send_beat(OP_DATA, 8'hFF, 8'hFF, 1'b1);
    send_beat(OP_IGNORED, 8'h00, 8'h00, 1'b0);
    send_beat(OP_DATA, 8'hA5, 8'h5A, 1'b0);
  endtask

  // A key length of zero acts as one byte; then a two-byte key.
  task automatic test_short_keys();
    set_key_length('0);
    send_beat(OP_KEY_WR, 8'h00, 8'hFF, 1'b0);
    send_beat(OP_KEY_WR, 8'hFF, 8'h00, 1'b1);
    run_key_schedule();
    send_message(3, 1'b0);
    set_key_length(KLEN_W'(2));
    send_beat(OP_KEY_WR, 8'h01, 8'h00, 1'b1);
    run_key_schedule();
    send_message(2, 1'b0);
    pause_stream();
  endtask

  // Key load, schedule and one message per session, at times a second one, with noise mixed in.
  task automatic test_random_sessions();
    int                session;
    int                n;
    int                r;
    logic [KLEN_W-1:0] len;
    session = 0;
    while (beats_sent < 680) begin
      send_gaps   = $urandom_range(0, 3) != 0;
      recv_stalls = $urandom_range(0, 3) != 0;
      case (session)
        0: set_key_length(KLEN_W'(1));
        1: set_key_length(KLEN_W'(MAX_KEY_BYTES));
        2: set_key_length('1);
        3: set_key_length(KLEN_W'(MAX_KEY_BYTES + 1));
        default: begin
          if ($urandom_range(0, 2) == 0) begin
            len = ($urandom_range(0, 7) == 0) ? KLEN_W'($urandom_range(0, 511))
                                              : KLEN_W'($urandom_range(1, 24));
            set_key_length(len);
          end
        end
      endcase
      n = $urandom_range(1, (used_key_bytes() < 12) ? used_key_bytes() : 12);
      repeat (n) begin
        send_beat(OP_KEY_WR, 8'($urandom_range(0, used_key_bytes() - 1)),
                  8'($urandom), 1'($urandom));
      end
      run_key_schedule();
      n = $urandom_range(1, 32);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 39);
        if (r == 0) send_beat(OP_IGNORED, 8'($urandom), 8'($urandom), 1'($urandom));
        else if (r == 1) send_beat(OP_KEY_WR, 8'($urandom), 8'($urandom), 1'($urandom));
        else if (r == 2) run_key_schedule();
        send_beat(OP_DATA, 8'($urandom), 8'($urandom), i == n - 1);
      end
      if ($urandom_range(0, 4) == 0) send_message($urandom_range(1, 8), 1'b1);
      if ($urandom_range(0, 5) == 0) pause_stream();
      session++;
    end
  endtask

  // Closing stretch with both sides running flat out.
  task automatic test_back_to_back();
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    repeat (4) send_beat(OP_KEY_WR, 8'($urandom_range(0, used_key_bytes() - 1)),
                         8'($urandom), 1'b0);
    run_key_schedule();
    send_message(40, 1'b1);
    send_message(20, 1'b0);
  endtask

  always @(posedge clk_i) begin : cipher_monitor
    cipher_beat_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_cipher.size() == 0) begin
          report_mismatch($sformatf("output beat %02h with nothing outstanding",
                                    m_axis_tdata));
        end else begin
          want = pending_cipher.pop_front();
          if (m_axis_tdata !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                      m_axis_tdata, want.out_byte));
          if (m_axis_tlast !== want.out_last)
            report_mismatch($sformatf("out_last %b, predicted %b",
                                      m_axis_tlast, want.out_last));
        end
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 9);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #1_600_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int n;
    for (int s = 0; s < TABLE_SIZE; s++) perm_mem[s] = BYTE_W'(s);
    for (int s = 0; s < MAX_KEY_BYTES; s++) begin
      key_mem[s]    = '0;
      key_loaded[s] = 1'b0;
    end
    ks_i        = '0;
    ks_j        = '0;
    key_len_reg = KEY_LENGTH_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_identity_permutation();
    test_short_keys();
    test_random_sessions();
    test_back_to_back();

    s_axis_tvalid <= 1'b0;
    for (n = 0; n < 5000 && pending_cipher.size() != 0; n++) @(posedge clk_i);
    if (pending_cipher.size() != 0)
      report_mismatch($sformatf("%0d cipher bytes never came out", pending_cipher.size()));
    repeat (32) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rc4_pkg.sv
rtl/rc4_ram.sv
rtl/rc4_perm_store.sv
rtl/rc4_adder.sv
rtl/rc4_stream_cipher_top.sv
bench/testbench.sv
